FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg: shared types for the two-phase commit coordinator
// Event, phase and status codes, the request and result records, and the
// phase encoder used on the status output.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // fixed field widths
  localparam int unsigned ReqW      = 3;
  localparam int unsigned RankW     = 2;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CountW    = 3;
  localparam int unsigned TotalW    = 3;

  // rank slots reachable through the rank field, and default participant limit
  localparam int unsigned RankSlots    = 4;
  localparam int unsigned MaxRanksDflt = 4;

  // event codes
  typedef enum logic [ReqW-1:0] {
    REQ_READY    = 3'd0,
    REQ_REJECT   = 3'd1,
    REQ_COMMIT   = 3'd2,
    REQ_CANCEL   = 3'd3,
    REQ_COMPLETE = 3'd4,
    REQ_FAILED   = 3'd5
  } req_e;

  // status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_PRECOND  = 3'd2,
    ST_UNAVAIL  = 3'd3,
    ST_INTERNAL = 3'd4,
    ST_FORWARD  = 3'd5
  } status_e;

  // coordinator phase, one-hot
  typedef enum logic [6:0] {
    PH_PREPARING = 7'b0000001,
    PH_READY     = 7'b0000010,
    PH_ABORTED   = 7'b0000100,
    PH_COMMITTED = 7'b0001000,
    PH_DRAINING  = 7'b0010000,
    PH_COMPLETE  = 7'b0100000,
    PH_POISONED  = 7'b1000000
  } phase_e;

  // phase codes as reported
  localparam logic [PhaseW-1:0] PhCodePreparing = 3'd0;
  localparam logic [PhaseW-1:0] PhCodeReady     = 3'd1;
  localparam logic [PhaseW-1:0] PhCodeAborted   = 3'd2;
  localparam logic [PhaseW-1:0] PhCodeCommitted = 3'd3;
  localparam logic [PhaseW-1:0] PhCodeDraining  = 3'd4;
  localparam logic [PhaseW-1:0] PhCodeComplete  = 3'd5;
  localparam logic [PhaseW-1:0] PhCodePoisoned  = 3'd6;

  // one event request
  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [RankW-1:0] rank;
    logic [CodeW-1:0] reason_code;
    logic [CodeW-1:0] txn_check_code;
    logic [CodeW-1:0] txn_action_code;
  } req_t;

  // one status result
  typedef struct packed {
    status_e           status_kind;
    logic [CodeW-1:0]  forwarded_code;
    logic [PhaseW-1:0] phase_now;
    logic              output_suppressed;
  } res_t;

  // one-hot phase to reported code
  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_PREPARING: code = PhCodePreparing;
      PH_READY:     code = PhCodeReady;
      PH_ABORTED:   code = PhCodeAborted;
      PH_COMMITTED: code = PhCodeCommitted;
      PH_DRAINING:  code = PhCodeDraining;
      PH_COMPLETE:  code = PhCodeComplete;
      PH_POISONED:  code = PhCodePoisoned;
      default:      code = PhCodePreparing;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/tpc_decide.sv
// ----------------------------------------------------------------------------
// tpc_decide: event decision logic
// Checks one event against the rank count, phase and bitmaps, and gives the
// next coordinator state together with the status for that event.
// ----------------------------------------------------------------------------
module tpc_decide #(
  parameter int unsigned MAX_RANKS = tpc_pkg::MaxRanksDflt,
  parameter int unsigned MarkW     = (MAX_RANKS < tpc_pkg::RankSlots) ?
                                     MAX_RANKS : tpc_pkg::RankSlots
) (
  input  tpc_pkg::req_t                    req_i,
  input  logic [tpc_pkg::CountW-1:0]       rank_count_i,
  input  tpc_pkg::phase_e                  phase_i,
  input  logic [MarkW-1:0]                 ready_marks_i,
  input  logic [tpc_pkg::TotalW-1:0]       ready_total_i,
  input  logic [MarkW-1:0]                 complete_marks_i,
  input  logic [tpc_pkg::TotalW-1:0]       complete_total_i,
  input  logic                             suppress_i,
  output tpc_pkg::phase_e                  phase_o,
  output logic [MarkW-1:0]                 ready_marks_o,
  output logic [tpc_pkg::TotalW-1:0]       ready_total_o,
  output logic [MarkW-1:0]                 complete_marks_o,
  output logic [tpc_pkg::TotalW-1:0]       complete_total_o,
  output logic                             suppress_o,
  output tpc_pkg::res_t                    res_o
);
  import tpc_pkg::*;

  logic [CountW-1:0] live;
  logic              rank_ok;
  logic [MarkW-1:0]  rank_bit;
  logic              in_prep;
  logic              in_exec;
  logic [TotalW-1:0] ready_inc;
  logic [TotalW-1:0] complete_inc;
  status_e           kind;
  logic [CodeW-1:0]  fwd;

  // participating ranks, clamped to the configured limit
  assign live = ({2'b00, rank_count_i} > 5'(MAX_RANKS)) ? CountW'(MAX_RANKS) : rank_count_i;
  assign rank_ok      = {1'b0, req_i.rank} < live;
  assign rank_bit     = MarkW'(1) << req_i.rank;
  assign in_prep      = (phase_i == PH_PREPARING) || (phase_i == PH_READY);
  assign in_exec      = (phase_i == PH_COMMITTED) || (phase_i == PH_DRAINING);
  assign ready_inc    = ready_total_i + TotalW'(1);
  assign complete_inc = complete_total_i + TotalW'(1);

  // event decision
  always_comb begin
    phase_o          = phase_i;
    ready_marks_o    = ready_marks_i;
    ready_total_o    = ready_total_i;
    complete_marks_o = complete_marks_i;
    complete_total_o = complete_total_i;
    suppress_o       = suppress_i;
    kind             = ST_OK;
    fwd              = '0;
    case (req_e'(req_i.req_type))
      REQ_READY: begin
        if (!rank_ok) begin
          kind = ST_INVALID;
        end else if (!in_prep || (ready_marks_i & rank_bit) != '0) begin
          kind = ST_PRECOND;
        end else begin
          ready_marks_o = ready_marks_i | rank_bit;
          ready_total_o = ready_inc;
          if (ready_inc == live) begin
            phase_o = PH_READY;
          end
        end
      end
      REQ_REJECT: begin
        if (!rank_ok) begin
          kind = ST_INVALID;
        end else if (!in_prep) begin
          kind = ST_PRECOND;
        end else if (req_i.txn_check_code != '0) begin
          kind = ST_FORWARD;
          fwd  = req_i.txn_check_code;
        end else if (req_i.txn_action_code != '0) begin
          phase_o    = PH_POISONED;
          suppress_o = 1'b1;
          kind       = ST_FORWARD;
          fwd        = req_i.txn_action_code;
        end else begin
          phase_o    = PH_ABORTED;
          suppress_o = 1'b1;
          if (req_i.reason_code == '0) begin
            kind = ST_UNAVAIL;
          end else begin
            kind = ST_FORWARD;
            fwd  = req_i.reason_code;
          end
        end
      end
      REQ_COMMIT: begin
        if (phase_i != PH_READY || ready_total_i != live) begin
          kind = ST_PRECOND;
        end else if (req_i.txn_check_code != '0) begin
          kind = ST_FORWARD;
          fwd  = req_i.txn_check_code;
        end else if (req_i.txn_action_code != '0) begin
          phase_o    = PH_POISONED;
          suppress_o = 1'b1;
          kind       = ST_FORWARD;
          fwd        = req_i.txn_action_code;
        end else begin
          phase_o = PH_COMMITTED;
        end
      end
      REQ_CANCEL: begin
        if (!in_exec) begin
          kind = ST_PRECOND;
        end else begin
          suppress_o = 1'b1;
          phase_o    = PH_DRAINING;
        end
      end
      REQ_COMPLETE: begin
        if (!rank_ok) begin
          kind = ST_INVALID;
        end else if (!in_exec || (complete_marks_i & rank_bit) != '0) begin
          kind = ST_PRECOND;
        end else if (complete_inc == live && req_i.txn_check_code != '0) begin
          kind = ST_FORWARD;
          fwd  = req_i.txn_check_code;
        end else begin
          complete_marks_o = complete_marks_i | rank_bit;
          complete_total_o = complete_inc;
          // last rank done: finish or poison on the action verdict
          if (complete_inc == live) begin
            if (req_i.txn_action_code != '0) begin
              phase_o    = PH_POISONED;
              suppress_o = 1'b1;
              kind       = ST_FORWARD;
              fwd        = req_i.txn_action_code;
            end else begin
              phase_o = PH_COMPLETE;
            end
          end
        end
      end
      REQ_FAILED: begin
        if (!rank_ok) begin
          kind = ST_INVALID;
        end else if (!in_exec) begin
          kind = ST_PRECOND;
        end else begin
          phase_o    = PH_POISONED;
          suppress_o = 1'b1;
          if (req_i.reason_code == '0) begin
            kind = ST_INTERNAL;
          end else begin
            kind = ST_FORWARD;
            fwd  = req_i.reason_code;
          end
        end
      end
      default: begin
        kind = ST_INVALID;
      end
    endcase
  end

  // status record
  assign res_o.status_kind       = kind;
  assign res_o.forwarded_code    = fwd;
  assign res_o.phase_now         = phase_code(phase_o);
  assign res_o.output_suppressed = suppress_o;

endmodule

FILE: rtl/two_phase_commit_coordinator.sv
// ----------------------------------------------------------------------------
// two_phase_commit_coordinator: commit coordinator for up to four ranks
// Tracks prepare and completion reports per rank and answers each event with
// one status, the resulting phase and the output-suppress flag.
// ----------------------------------------------------------------------------
// Each accepted event is decided in the cycle it is taken, against the
// registered phase and rank bitmaps, and its status is registered in the
// result register; one event can be taken every cycle while results are
// drained. The result register is backed by a one-entry skid stage that lets
// one more event in while a result waits, so in_stall_o rises only once both
// hold a result. The user writes rank_count through the cfg port only while
// the block is idle, which the block does not enforce; it takes effect on the
// next event, values above MAX_RANKS act as MAX_RANKS and zero makes every
// rank invalid. After reset the phase is preparing and rank_count is 1.
module two_phase_commit_coordinator #(
  parameter int unsigned MAX_RANKS = tpc_pkg::MaxRanksDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tpc_pkg::ReqW-1:0]      req_type_i,
  input  logic [tpc_pkg::RankW-1:0]     rank_i,
  input  logic [tpc_pkg::CodeW-1:0]     reason_code_i,
  input  logic [tpc_pkg::CodeW-1:0]     txn_check_code_i,
  input  logic [tpc_pkg::CodeW-1:0]     txn_action_code_i,
  // status channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tpc_pkg::StatusW-1:0]   status_kind_o,
  output logic [tpc_pkg::CodeW-1:0]     forwarded_code_o,
  output logic [tpc_pkg::PhaseW-1:0]    phase_now_o,
  output logic                          output_suppressed_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tpc_pkg::CountW-1:0]    cfg_data_i
);
  import tpc_pkg::*;

  localparam int unsigned MarkW = (MAX_RANKS < RankSlots) ? MAX_RANKS : RankSlots;

  logic [CountW-1:0] rank_count_q;
  phase_e            phase_q, phase_d;
  logic [MarkW-1:0]  ready_marks_q, ready_marks_d;
  logic [TotalW-1:0] ready_total_q, ready_total_d;
  logic [MarkW-1:0]  complete_marks_q, complete_marks_d;
  logic [TotalW-1:0] complete_total_q, complete_total_d;
  logic              suppress_q, suppress_d;

  logic              out_valid_q;
  res_t              out_res_q;
  logic              skid_valid_q;
  res_t              skid_res_q;

  req_t              req;
  res_t              res;
  logic              in_acc;
  logic              out_free;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= CountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      rank_count_q <= cfg_data_i;
    end
  end

  // request record
  assign req.req_type        = req_type_i;
  assign req.rank            = rank_i;
  assign req.reason_code     = reason_code_i;
  assign req.txn_check_code  = txn_check_code_i;
  assign req.txn_action_code = txn_action_code_i;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  tpc_decide #(
    .MAX_RANKS (MAX_RANKS),
    .MarkW     (MarkW)
  ) u_decide (
    .req_i            (req),
    .rank_count_i     (rank_count_q),
    .phase_i          (phase_q),
    .ready_marks_i    (ready_marks_q),
    .ready_total_i    (ready_total_q),
    .complete_marks_i (complete_marks_q),
    .complete_total_i (complete_total_q),
    .suppress_i       (suppress_q),
    .phase_o          (phase_d),
    .ready_marks_o    (ready_marks_d),
    .ready_total_o    (ready_total_d),
    .complete_marks_o (complete_marks_d),
    .complete_total_o (complete_total_d),
    .suppress_o       (suppress_d),
    .res_o            (res)
  );

  // coordinator state, updated on each accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_PREPARING;
      ready_marks_q    <= '0;
      ready_total_q    <= '0;
      complete_marks_q <= '0;
      complete_total_q <= '0;
      suppress_q       <= 1'b0;
    end else if (in_acc) begin
      phase_q          <= phase_d;
      ready_marks_q    <= ready_marks_d;
      ready_total_q    <= ready_total_d;
      complete_marks_q <= complete_marks_d;
      complete_total_q <= complete_total_d;
      suppress_q       <= suppress_d;
    end
  end

  // result register and skid stage, control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result register and skid stage, payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_res_q <= skid_valid_q ? skid_res_q : res;
    end else if (in_acc) begin
      skid_res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_kind_o       = out_res_q.status_kind;
  assign forwarded_code_o    = out_res_q.forwarded_code;
  assign phase_now_o         = out_res_q.phase_now;
  assign output_suppressed_o = out_res_q.output_suppressed;

`ifndef SYNTHESIS
  // skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the result register is empty");

  // a held result with an incoming event lands in the skid stage
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_acc) |=> skid_valid_q)
    else $error("event accepted behind a held result was lost");

  // ready count tracks the ready bitmap
  a_ready_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_total_q == TotalW'($countones(ready_marks_q)))
    else $error("ready count disagrees with ready bitmap");

  // complete count tracks the complete bitmap
  a_complete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    complete_total_q == TotalW'($countones(complete_marks_q)))
    else $error("complete count disagrees with complete bitmap");

  // suppress flag never clears once set
  a_suppress_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    suppress_q |=> suppress_q)
    else $error("output suppress flag cleared");
`endif

endmodule

FILE: tb/tb_two_phase_commit_coordinator.sv
// ----------------------------------------------------------------------------
// tb_two_phase_commit_coordinator: self-checking bench for the coordinator
// Sends event requests in random bursts against a receiver that stalls in
// changing patterns. A scoreboard predicts the phase and the rank bitmaps,
// queues the expected status of every accepted request and compares each
// status result field by field. rank_count is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_two_phase_commit_coordinator;
  import tpc_pkg::*;

  localparam int unsigned MaxRanks    = MaxRanksDflt;
  localparam int unsigned ChunkItems  = 188;
  localparam int unsigned RandomItems = 6 * ChunkItems;
  localparam int unsigned EndStretch  = 150;
  localparam int unsigned IdleCycles  = 4;
  localparam int unsigned CycleLimit  = 400000;

  // event codes beyond the defined set
  localparam logic [ReqW-1:0] ReqUnknownLo = 3'd6;
  localparam logic [ReqW-1:0] ReqUnknownHi = 3'd7;

  // predicted coordinator state
  typedef struct packed {
    logic [PhaseW-1:0]    phase;
    logic [RankSlots-1:0] ready_marks;
    logic [TotalW-1:0]    ready_total;
    logic [RankSlots-1:0] complete_marks;
    logic [TotalW-1:0]    complete_total;
    logic                 suppress;
  } coord_state_t;

  // status prediction and checking
  class commit_scoreboard;
    coord_state_t      st;
    logic [CountW-1:0] rank_count;
    res_t              status_q[$];
    int unsigned       errors;

    function new();
      st         = '0;
      st.phase   = PhCodePreparing;
      rank_count = 3'd1;
      errors     = 0;
    endfunction

    function int unsigned live_ranks();
      return (rank_count > MaxRanks) ? MaxRanks : int'(rank_count);
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    // phase poisoned, output suppressed, zero code reported as internal
    function void poison(input logic [CodeW-1:0] code, inout coord_state_t s,
                         inout res_t o);
      s.phase    = PhCodePoisoned;
      s.suppress = 1'b1;
      if (code == '0) begin
        o.status_kind = ST_INTERNAL;
      end else begin
        o.status_kind    = ST_FORWARD;
        o.forwarded_code = code;
      end
    endfunction

    // decide one event against state s, returning its status
    function res_t decide(input req_t r, inout coord_state_t s);
      res_t                 o;
      int unsigned          live;
      logic [RankSlots-1:0] rank_bit;
      logic                 rank_ok;
      logic                 in_prep;
      logic                 in_exec;
      live     = live_ranks();
      rank_bit = 4'b0001 << r.rank;
      rank_ok  = r.rank < live;
      in_prep  = (s.phase == PhCodePreparing) || (s.phase == PhCodeReady);
      in_exec  = (s.phase == PhCodeCommitted) || (s.phase == PhCodeDraining);
      o.status_kind    = ST_OK;
      o.forwarded_code = '0;
      case (r.req_type)
        REQ_READY: begin
          if (!rank_ok) begin
            o.status_kind = ST_INVALID;
          end else if (!in_prep || (s.ready_marks & rank_bit) != '0) begin
            o.status_kind = ST_PRECOND;
          end else begin
            s.ready_marks = s.ready_marks | rank_bit;
            s.ready_total = s.ready_total + 1'b1;
            if (s.ready_total == live) s.phase = PhCodeReady;
          end
        end
        REQ_REJECT: begin
          if (!rank_ok) begin
            o.status_kind = ST_INVALID;
          end else if (!in_prep) begin
            o.status_kind = ST_PRECOND;
          end else if (r.txn_check_code != '0) begin
            o.status_kind    = ST_FORWARD;
            o.forwarded_code = r.txn_check_code;
          end else if (r.txn_action_code != '0) begin
            poison(r.txn_action_code, s, o);
          end else begin
            s.phase    = PhCodeAborted;
            s.suppress = 1'b1;
            if (r.reason_code == '0) begin
              o.status_kind = ST_UNAVAIL;
            end else begin
              o.status_kind    = ST_FORWARD;
              o.forwarded_code = r.reason_code;
            end
          end
        end
        REQ_COMMIT: begin
          if (s.phase != PhCodeReady || s.ready_total != live) begin
            o.status_kind = ST_PRECOND;
          end else if (r.txn_check_code != '0) begin
            o.status_kind    = ST_FORWARD;
            o.forwarded_code = r.txn_check_code;
          end else if (r.txn_action_code != '0) begin
            poison(r.txn_action_code, s, o);
          end else begin
            s.phase = PhCodeCommitted;
          end
        end
        REQ_CANCEL: begin
          if (!in_exec) begin
            o.status_kind = ST_PRECOND;
          end else begin
            s.suppress = 1'b1;
            s.phase    = PhCodeDraining;
          end
        end
        REQ_COMPLETE: begin
          if (!rank_ok) begin
            o.status_kind = ST_INVALID;
          end else if (!in_exec || (s.complete_marks & rank_bit) != '0) begin
            o.status_kind = ST_PRECOND;
          end else if (int'(s.complete_total) + 1 == int'(live) &&
                       r.txn_check_code != '0) begin
            o.status_kind    = ST_FORWARD;
            o.forwarded_code = r.txn_check_code;
          end else begin
            s.complete_marks = s.complete_marks | rank_bit;
            s.complete_total = s.complete_total + 1'b1;
            // the last completion closes the transaction
            if (s.complete_total == live) begin
              if (r.txn_action_code != '0) poison(r.txn_action_code, s, o);
              else s.phase = PhCodeComplete;
            end
          end
        end
        REQ_FAILED: begin
          if (!rank_ok) o.status_kind = ST_INVALID;
          else if (!in_exec) o.status_kind = ST_PRECOND;
          else poison(r.reason_code, s, o);
        end
        default: o.status_kind = ST_INVALID;
      endcase
      o.phase_now         = s.phase;
      o.output_suppressed = s.suppress;
      return o;
    endfunction

    // accepted request: advance the prediction and queue its status
    function void note_event(input req_t r);
      status_q.push_back(decide(r, st));
    endfunction

    // accepted result: compare with the oldest expected status
    function void check_status(input logic [StatusW-1:0] kind,
                               input logic [CodeW-1:0] code,
                               input logic [PhaseW-1:0] ph, input logic supp);
      res_t exp_r;
      if (status_q.size() == 0) begin
        $error("status result with no request outstanding");
        errors++;
        return;
      end
      exp_r = status_q.pop_front();
      if (kind !== exp_r.status_kind) begin
        $error("status_kind: expected %0d, actual %0d", exp_r.status_kind, kind);
        errors++;
      end
      if (code !== exp_r.forwarded_code) begin
        $error("forwarded_code: expected %0d, actual %0d", exp_r.forwarded_code, code);
        errors++;
      end
      if (ph !== exp_r.phase_now) begin
        $error("phase_now: expected %0d, actual %0d", exp_r.phase_now, ph);
        errors++;
      end
      if (supp !== exp_r.output_suppressed) begin
        $error("output_suppressed: expected %0d, actual %0d",
               exp_r.output_suppressed, supp);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ReqW-1:0]     req_type_i = '0;
  logic [RankW-1:0]    rank_i = '0;
  logic [CodeW-1:0]    reason_code_i = '0;
  logic [CodeW-1:0]    txn_check_code_i = '0;
  logic [CodeW-1:0]    txn_action_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_kind_o;
  logic [CodeW-1:0]    forwarded_code_o;
  logic [PhaseW-1:0]   phase_now_o;
  logic                output_suppressed_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i = '0;

  commit_scoreboard    sb = new();
  int unsigned         random_sent = 0;
  int unsigned         stall_pct = 0;
  int unsigned         stall_left = 0;

  two_phase_commit_coordinator #(
    .MAX_RANKS (MaxRanks)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .rank_i              (rank_i),
    .reason_code_i       (reason_code_i),
    .txn_check_code_i    (txn_check_code_i),
    .txn_action_code_i   (txn_action_code_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_kind_o       (status_kind_o),
    .forwarded_code_o    (forwarded_code_o),
    .phase_now_o         (phase_now_o),
    .output_suppressed_o (output_suppressed_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver stall, new stall density every stretch of cycles
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_status(status_kind_o, forwarded_code_o, phase_now_o, output_suppressed_o);
    end
  end

  // watchdog
  initial begin
    for (int unsigned n = 0; n < CycleLimit; n++) @(posedge clk_i);
    $display("two_phase_commit_coordinator test failed");
    $finish;
  end

  function automatic req_t make_req(input logic [ReqW-1:0] kind,
                                    input logic [RankW-1:0] rank,
                                    input logic [CodeW-1:0] reason,
                                    input logic [CodeW-1:0] check,
                                    input logic [CodeW-1:0] action);
    req_t r;
    r.req_type        = kind;
    r.rank            = rank;
    r.reason_code     = reason;
    r.txn_check_code  = check;
    r.txn_action_code = action;
    return r;
  endfunction

  // zero at least half of the time, so that clean verdicts are common
  function automatic logic [CodeW-1:0] pick_code();
    return $urandom_range(0, 1) ? '0 : CodeW'($urandom_range(0, 15));
  endfunction

  function automatic logic phase_final(input logic [PhaseW-1:0] ph);
    return (ph == PhCodeAborted) || (ph == PhCodeComplete) || (ph == PhCodePoisoned);
  endfunction

  // mostly well-formed events for the current phase; events that would close
  // the transaction are held back until the closing stretch
  function automatic req_t random_req(input logic allow_end);
    req_t         r;
    coord_state_t trial;
    int unsigned  live;
    int unsigned  pick;
    logic         in_prep;
    logic         in_exec;
    logic         closes;
    live    = sb.live_ranks();
    in_prep = (sb.st.phase == PhCodePreparing) || (sb.st.phase == PhCodeReady);
    in_exec = (sb.st.phase == PhCodeCommitted) || (sb.st.phase == PhCodeDraining);
    do begin
      r = make_req(ReqW'($urandom_range(0, 7)), RankW'($urandom_range(0, 3)),
                   pick_code(), pick_code(), pick_code());
      pick = $urandom_range(0, 99);
      if (pick >= 25 && in_prep) begin
        if (sb.st.phase == PhCodeReady && pick < 55) begin
          r.req_type = REQ_COMMIT;
        end else if (pick < 88) begin
          r.req_type = REQ_READY;
          if (live > 0) r.rank = RankW'($urandom_range(0, live - 1));
        end else begin
          r.req_type = REQ_REJECT;
        end
      end else if (pick >= 25 && in_exec) begin
        if (pick < 35) begin
          r.req_type = REQ_CANCEL;
        end else if (pick < 45) begin
          r.req_type = REQ_FAILED;
        end else begin
          r.req_type = REQ_COMPLETE;
          if (live > 0) r.rank = RankW'($urandom_range(0, live - 1));
        end
      end
      trial = sb.st;
      void'(sb.decide(r, trial));
      closes = !phase_final(sb.st.phase) && phase_final(trial.phase);
    end while (closes && !(allow_end && $urandom_range(0, 7) == 0));
    return r;
  endfunction

  // present one request, wait for its acceptance, then idle for the given gap
  task automatic issue(input req_t r, input int unsigned gap);
    in_valid_i        <= 1'b1;
    req_type_i        <= r.req_type;
    rank_i            <= r.rank;
    reason_code_i     <= r.reason_code;
    txn_check_code_i  <= r.txn_check_code;
    txn_action_code_i <= r.txn_action_code;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(r);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain every outstanding status, let the block settle, then write
  task automatic write_rank_count(input logic [CountW-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    sb.rank_count = value;
  endtask

  // random requests in bursts separated by random gaps
  task automatic run_chunk(input int unsigned n_items);
    int unsigned done_n;
    int unsigned burst;
    int unsigned gap;
    done_n = 0;
    while (done_n < n_items) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int unsigned b = 0; b < burst && done_n < n_items; b++) begin
        issue(random_req(random_sent >= RandomItems - EndStretch),
              (b + 1 == burst) ? gap : 0);
        done_n++;
        random_sent++;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [CountW-1:0] schedule [6];
    schedule = '{3'd3, 3'd7, 3'd5, 3'd6, 3'd1, 3'd4};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one rank: unknown events, bad ranks, events out of phase
    issue(make_req(ReqUnknownLo, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(ReqUnknownHi, 2'd3, 4'd15, 4'd15, 4'd15), $urandom_range(0, 2));
    issue(make_req(REQ_READY, 2'd1, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_COMMIT, 2'd3, 4'd15, 4'd15, 4'd15), $urandom_range(0, 2));
    issue(make_req(REQ_CANCEL, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_COMPLETE, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_FAILED, 2'd0, 4'd5, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_REJECT, 2'd0, 4'd15, 4'd15, 4'd15), $urandom_range(0, 2));
    issue(make_req(REQ_REJECT, 2'd3, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_READY, 2'd0, 4'd15, 4'd15, 4'd15), $urandom_range(0, 2));
    issue(make_req(REQ_READY, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_COMMIT, 2'd0, 4'd0, 4'd3, 4'd0), $urandom_range(0, 2));

    // no ranks: every ranked event is invalid, counts no longer match
    write_rank_count(3'd0);
    issue(make_req(REQ_READY, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_REJECT, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_COMPLETE, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_FAILED, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_COMMIT, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));

    // two ranks: commit before all ready, forwarded reject, rank past the count
    write_rank_count(3'd2);
    issue(make_req(REQ_COMMIT, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_READY, 2'd1, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_REJECT, 2'd1, 4'd0, 4'd10, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_READY, 2'd2, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));
    issue(make_req(REQ_CANCEL, 2'd0, 4'd0, 4'd0, 4'd0), $urandom_range(0, 2));

    // random phases, one rank_count setting each
    for (int c = 0; c < 6; c++) begin
      write_rank_count(schedule[c]);
      run_chunk(ChunkItems);
    end

    // drain and settle
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("two_phase_commit_coordinator test passed");
    end else begin
      $display("two_phase_commit_coordinator test failed");
    end
    $finish;
  end

endmodule

FILE: two_phase_commit_coordinator.f
rtl/tpc_pkg.sv
rtl/tpc_decide.sv
rtl/two_phase_commit_coordinator.sv
tb/tb_two_phase_commit_coordinator.sv
